// File: rtl/core/csfc_pkg.sv
// Shared types and constants for the color sensor frequency counter.
// No dependencies; imported by csfc_div and color_sensor_frequency_counter.
`default_nettype none

package csfc_pkg;

    // Number of filter selections stepped through per run (1 to 4).
    localparam int CHANNELS = 3;

    localparam int SLOTS    = 4;    // channel index range (2-bit channel)
    localparam int CH_W     = 2;
    localparam int WINDOW_W = 16;
    localparam int EDGE_W   = 15;
    localparam int READ_W   = 9;
    localparam int QUOT_W   = 8;
    localparam int DIV_W    = EDGE_W + QUOT_W;   // 255*count fits here
    localparam int STEP_W   = 4;                 // divider step counter

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd20000;
    localparam logic [STEP_W-1:0]   STEP_LAST    = STEP_W'(QUOT_W);

    localparam logic signed [READ_W-1:0] READ_NONE = -9'sd1;
    localparam logic signed [READ_W-1:0] READ_MAX  = 9'sd255;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CAL    = 2'd1;
    localparam logic [1:0] CMD_MEAS   = 2'd2;

    localparam logic [CH_W-1:0] FILTER_R = 2'd0;
    localparam logic [CH_W-1:0] FILTER_G = 2'd1;
    localparam logic [CH_W-1:0] FILTER_B = 2'd2;
    localparam logic [CH_W-1:0] FILTER_C = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_CAL  = 2'd1,
        MODE_MEAS = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DIV  = 2'd1,
        ST_EMIT = 2'd2
    } t_state;

    typedef struct packed {
        logic              start;
        logic [EDGE_W-1:0] numer;
        logic [EDGE_W-1:0] denom;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              clip;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

endpackage

`default_nettype wire

// File: rtl/core/csfc_div.sv
// Bit-serial restoring divider: floor(255*numer/denom), clipped to 255.
// Depends on csfc_pkg.
`default_nettype none

module csfc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csfc_pkg::t_div_req  i_req,
    output csfc_pkg::t_div_res  o_res
);
    import csfc_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic              r_clip, n_clip;
    logic [STEP_W-1:0] r_cnt,  n_cnt;
    logic [DIV_W-1:0]  r_rem,  n_rem;
    logic [DIV_W-1:0]  r_dvs,  n_dvs;
    logic [QUOT_W-1:0] r_quot, n_quot;
    logic [DIV_W:0]    diff;
    logic              ge;

    always_comb begin
        diff   = {1'b0, r_rem} - {1'b0, r_dvs};
        ge     = !diff[DIV_W];
        n_busy = r_busy;
        n_done = 1'b0;
        n_clip = r_clip;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quot = r_quot;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            // 255*x = 256*x - x
            n_rem  = {i_req.numer, {QUOT_W{1'b0}}} - DIV_W'(i_req.numer);
            n_dvs  = {i_req.denom, {QUOT_W{1'b0}}};
            n_quot = '0;
            n_clip = 1'b0;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                // first step only tests for a quotient of 256 or more
                if (ge) begin
                    n_clip = 1'b1;
                    n_quot = '1;
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end else begin
                n_quot = {r_quot[QUOT_W-2:0], ge};
                if (ge) begin
                    n_rem = diff[DIV_W-1:0];
                end
                if (r_cnt == STEP_LAST) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
            n_dvs = r_dvs >> 1;
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clip <= n_clip;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quot <= n_quot;
    end

    assign o_res = '{done: r_done, clip: r_clip, quot: r_quot};

endmodule

`default_nettype wire

// File: rtl/core/color_sensor_frequency_counter.sv
// Color sensor gated frequency counter with white calibration, top level.
// Depends on csfc_pkg and csfc_div.
//
//   channel   valid        stall        payload
//   input     i_in_valid   o_in_stall   i_command, i_level
//   output    o_out_valid  i_out_stall  o_filter_s2 .. o_saturated
//   config    i_cfg_we     (none)       i_cfg_data (window_samples)
//
// One beat in, one beat out.
// A measurement beat that closes a channel with a nonzero calibration count
// runs the serial divider (one quotient bit per cycle); no further beat is
// accepted until the quotient is written back and its beat loaded, and a
// reading that clips at 255 ends the divide after its first step.
// Synchronous active-low reset; no clearing pass.
// Input is stalled while a divide or its result beat is pending, or while the
// output register is full and stalled downstream.
`default_nettype none

module color_sensor_frequency_counter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input beats
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_command,
    input  logic                                  i_level,
    // output beats
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_filter_s2,
    output logic                                  o_filter_s3,
    output logic                                  o_power_on,
    output logic                                  o_busy_res,
    output logic                                  o_done_res,
    output logic                                  o_was_calibration,
    output logic signed [csfc_pkg::READ_W-1:0]    o_red,
    output logic signed [csfc_pkg::READ_W-1:0]    o_green,
    output logic signed [csfc_pkg::READ_W-1:0]    o_blue,
    output logic                                  o_saturated,
    // window register
    input  logic                                  i_cfg_we,
    input  logic [csfc_pkg::WINDOW_W-1:0]         i_cfg_data
);
    import csfc_pkg::*;

    // control state
    t_state              r_state,  n_state;
    t_mode               r_mode,   n_mode;
    logic [CH_W-1:0]     r_chan,   n_chan;
    logic [WINDOW_W-1:0] r_scnt,   n_scnt;
    logic [EDGE_W-1:0]   r_edge,   n_edge;
    logic                r_prev,   n_prev;
    logic                r_clip,   n_clip;
    logic [WINDOW_W-1:0] r_window;
    logic [EDGE_W-1:0]   r_cal  [SLOTS];
    logic [EDGE_W-1:0]   n_cal  [SLOTS];
    logic signed [READ_W-1:0] r_read [SLOTS];
    logic signed [READ_W-1:0] n_read [SLOTS];
    logic [CH_W-1:0]     r_div_idx, n_div_idx;
    logic                r_pend_done, n_pend_done;
    logic                r_pend_cal,  n_pend_cal;
    logic                r_out_valid, n_out_valid;

    // output register payload
    logic                r_s2, r_s3, r_busy, r_done, r_wcal, r_sat;
    logic signed [READ_W-1:0] r_o_red, r_o_green, r_o_blue;

    // per-beat working values
    logic                slot_free;
    logic                accept;
    logic                load;
    logic                f_done, f_wcal;
    logic [EDGE_W-1:0]   edge_inc;
    logic [WINDOW_W-1:0] scnt_inc;
    logic [WINDOW_W-1:0] win_eff;
    logic [CH_W-1:0]     chan_nxt;
    logic                run_end;
    logic                v_busy, v_s2, v_s3;

    t_div_req            div_req;
    t_div_res            div_res;

    csfc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_RUN) && slot_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        edge_inc = r_edge + EDGE_W'(!r_prev && i_level);
        scnt_inc = r_scnt + 1'b1;
        win_eff  = (r_window == '0) ? WINDOW_W'(1) : r_window;
        chan_nxt = r_chan + 1'b1;
        // run ends past the last channel or when the index wraps
        run_end  = ({1'b0, chan_nxt} >= (CH_W + 1)'(CHANNELS)) || (chan_nxt == '0);
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_chan      = r_chan;
        n_scnt      = r_scnt;
        n_edge      = r_edge;
        n_prev      = r_prev;
        n_clip      = r_clip;
        n_cal       = r_cal;
        n_read      = r_read;
        n_div_idx   = r_div_idx;
        n_pend_done = r_pend_done;
        n_pend_cal  = r_pend_cal;
        load        = 1'b0;
        f_done      = 1'b0;
        f_wcal      = 1'b0;
        div_req     = '{start: 1'b0, numer: edge_inc, denom: r_cal[r_chan]};

        unique case (r_state)
            ST_RUN: begin
                if (accept) begin
                    load = 1'b1;
                    if (r_mode == MODE_IDLE) begin
                        if (i_command == CMD_CAL || i_command == CMD_MEAS) begin
                            n_mode = (i_command == CMD_CAL) ? MODE_CAL : MODE_MEAS;
                            n_chan = FILTER_R;
                            n_scnt = '0;
                            n_edge = '0;
                            n_prev = 1'b1;
                            if (i_command == CMD_MEAS) begin
                                for (int i = 0; i < SLOTS; i++) begin
                                    n_read[i] = READ_NONE;
                                end
                                n_clip = 1'b0;
                            end
                        end
                    end else if (i_command == CMD_SAMPLE) begin
                        n_edge = edge_inc;
                        n_prev = i_level;
                        n_scnt = scnt_inc;
                        if (scnt_inc >= win_eff) begin
                            // window closed: store or scale this channel
                            if (r_mode == MODE_CAL) begin
                                n_cal[r_chan] = edge_inc;
                            end else if (r_cal[r_chan] == '0) begin
                                n_read[r_chan] = READ_NONE;
                            end else begin
                                div_req.start = 1'b1;
                                n_div_idx     = r_chan;
                                n_state       = ST_DIV;
                                load          = 1'b0;
                            end
                            n_chan = chan_nxt;
                            n_scnt = '0;
                            n_edge = '0;
                            n_prev = 1'b1;
                            if (run_end) begin
                                f_done = 1'b1;
                                f_wcal = (r_mode == MODE_CAL);
                                n_mode = MODE_IDLE;
                                n_chan = FILTER_R;
                            end
                            n_pend_done = f_done;
                            n_pend_cal  = f_wcal;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    n_read[r_div_idx] = div_res.clip ? READ_MAX
                                                     : $signed({1'b0, div_res.quot});
                    n_clip  = r_clip | div_res.clip;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                f_done = r_pend_done;
                f_wcal = r_pend_cal;
                if (slot_free) begin
                    load    = 1'b1;
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // filter select and run flags as seen after the beat
    always_comb begin
        v_busy = (n_mode != MODE_IDLE);
        v_s2   = 1'b0;
        v_s3   = 1'b0;
        if (v_busy) begin
            unique case (n_chan)
                FILTER_R: begin v_s2 = 1'b0; v_s3 = 1'b0; end
                FILTER_G: begin v_s2 = 1'b1; v_s3 = 1'b1; end
                FILTER_B: begin v_s2 = 1'b0; v_s3 = 1'b1; end
                FILTER_C: begin v_s2 = 1'b1; v_s3 = 1'b0; end
            endcase
        end
    end

    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_mode      <= MODE_IDLE;
            r_chan      <= FILTER_R;
            r_scnt      <= '0;
            r_edge      <= '0;
            r_prev      <= 1'b1;
            r_clip      <= 1'b0;
            r_window    <= WINDOW_RESET;
            r_out_valid <= 1'b0;
            r_pend_done <= 1'b0;
            r_pend_cal  <= 1'b0;
            r_div_idx   <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_cal[i]  <= '0;
                r_read[i] <= READ_NONE;
            end
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_chan      <= n_chan;
            r_scnt      <= n_scnt;
            r_edge      <= n_edge;
            r_prev      <= n_prev;
            r_clip      <= n_clip;
            r_out_valid <= n_out_valid;
            r_pend_done <= n_pend_done;
            r_pend_cal  <= n_pend_cal;
            r_div_idx   <= n_div_idx;
            r_cal       <= n_cal;
            r_read      <= n_read;
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
        end
    end

    // output payload, loaded with the state the beat leaves behind
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s2      <= v_s2;
            r_s3      <= v_s3;
            r_busy    <= v_busy;
            r_done    <= f_done;
            r_wcal    <= f_wcal;
            r_o_red   <= n_read[FILTER_R];
            r_o_green <= n_read[FILTER_G];
            r_o_blue  <= n_read[FILTER_B];
            r_sat     <= n_clip;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_filter_s2       = r_s2;
    assign o_filter_s3       = r_s3;
    assign o_power_on        = r_busy;
    assign o_busy_res        = r_busy;
    assign o_done_res        = r_done;
    assign o_was_calibration = r_wcal;
    assign o_red             = r_o_red;
    assign o_green           = r_o_green;
    assign o_blue            = r_o_blue;
    assign o_saturated       = r_sat;

    // no beat is taken unless the sequencer is free
    a_stall_when_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> o_in_stall)
        else $error("input taken while divide pending");

    // divider reports only when a divide was launched
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == ST_DIV))
        else $error("stray divider completion");

    // a finished run leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (!o_busy_res && !o_filter_s2 && !o_filter_s3))
        else $error("run done but still busy");

    // a launched divide always ends in a pending result beat
    a_div_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && div_res.done) |=> (r_state == ST_EMIT))
        else $error("divide result dropped");

endmodule

`default_nettype wire
